// File: sv/pjd2e_pkg.sv
// ----------------------------------------------------------------------------
// pjd2e_pkg
// Types, constants and the packed-decimal digit step shared by the packed
// Julian date to epoch converter.
// ----------------------------------------------------------------------------
`default_nettype none

package pjd2e_pkg;

	localparam int unsigned DATE_W = 28;   // unpacked date, up to eight digits
	localparam int unsigned TIM_W  = 15;   // unpacked HHMM, up to four digits
	localparam int unsigned SEC_W  = 8;    // unpacked SS
	localparam int unsigned Q1_W   = 18;   // date / 1000
	localparam int unsigned CQ_W   = 11;   // date / 100000
	localparam int unsigned HR_W   = 8;
	localparam int unsigned MN_W   = 7;
	localparam int unsigned DAY_W  = 10;
	localparam int unsigned YEAR_W = 12;   // years up to 2099
	localparam int unsigned TSEC_W = 20;   // seconds within the day, rolled over
	localparam int unsigned DAYS_W = 18;   // signed day count from the epoch
	localparam int unsigned DSEC_W = 34;   // signed seconds of whole days
	localparam int unsigned OUT_W  = 33;

	localparam logic [3:0] NIBBLE_STOP = 4'hA;

	// reciprocals for exact constant division over the value ranges in use
	localparam logic [28:0] RECIP_1000_D = 29'd274877907;   // 2^38 / 1000, rounded up
	localparam int unsigned SHIFT_1000_D = 38;
	localparam logic [18:0] RECIP_100_D  = 19'd335545;      // 2^25 / 100, rounded up
	localparam int unsigned SHIFT_100_D  = 25;
	localparam logic [14:0] RECIP_100_T  = 15'd20972;       // 2^21 / 100, rounded up
	localparam int unsigned SHIFT_100_T  = 21;

	localparam logic [YEAR_W-1:0] YEAR_1900 = 12'd1900;
	localparam logic [YEAR_W-1:0] YEAR_2000 = 12'd2000;
	localparam logic [YEAR_W-1:0] YEAR_1970 = 12'd1970;
	localparam int unsigned LEAPS_1970 = 477;

	typedef struct packed {
		logic [DATE_W-1:0] acc;
		logic              stop;
	} unp_t;

	// one packed byte: high nibble taken unless an earlier sign stopped the number, low nibble unless it is a sign
	function automatic unp_t unpack_byte(unp_t prev, logic [7:0] byte_in);
		unp_t       r;
		logic [3:0] hi;
		logic [3:0] lo;
		r  = prev;
		hi = byte_in[7:4];
		lo = byte_in[3:0];
		if (!prev.stop) begin
			r.acc = (r.acc << 3) + (r.acc << 1) + DATE_W'(hi);
			if (lo >= NIBBLE_STOP) begin
				r.stop = 1'b1;
			end else begin
				r.acc = (r.acc << 3) + (r.acc << 1) + DATE_W'(lo);
			end
		end
		return r;
	endfunction

	function automatic unp_t unpack_two(unp_t prev, logic [15:0] bytes_in);
		unp_t r;
		r = unpack_byte(prev, bytes_in[15:8]);
		r = unpack_byte(r, bytes_in[7:0]);
		return r;
	endfunction

endpackage

`default_nettype wire

// File: sv/packed_julian_date_to_epoch_unit.sv
// ----------------------------------------------------------------------------
// packed_julian_date_to_epoch_unit
// Converts a packed-decimal 0CYYDDDF date, HHMM time and SS seconds request
// into signed seconds since 1970-01-01 00:00:00 UTC.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------
//  input    | in_valid / in_stall     | date_bytes, time_bytes, seconds_byte
//  output   | out_valid / out_stall   | epoch_seconds (33 bit signed)
//
//  eight register stages; a request enters every cycle while in_stall is low
//  the stages carry the digit unpacking, the three reciprocal divisions and
//  the day count
//  arst_n clears the stage valid bits only; data registers are not reset
//  a stall on the output holds the full stages; bubbles still close up, so
//  in_stall rises only when every stage holds a request
// ----------------------------------------------------------------------------
`default_nettype none

module packed_julian_date_to_epoch_unit
	import pjd2e_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [31:0]            date_bytes,
	input  wire logic [15:0]            time_bytes,
	input  wire logic [7:0]             seconds_byte,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic signed [OUT_W-1:0]     epoch_seconds
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic en1, en2, en3, en4, en5, en6, en7, en8;

	assign en8 = !v_s8 || !out_stall;
	assign en7 = !v_s7 || en8;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign in_stall  = !en1;
	assign out_valid = v_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
			if (en8) v_s8 <= v_s7;
		end
	end

	// stage 1: upper date bytes, whole time and seconds
	unp_t              dhi_c;
	unp_t              tim_c;
	logic [SEC_W-1:0]  sec_c;
	unp_t              dhi_s1;
	logic [15:0]       dlo_s1;
	logic [TIM_W-1:0]  tim_s1;
	logic [SEC_W-1:0]  sec_s1;

	assign dhi_c = unpack_two('0, date_bytes[31:16]);
	assign tim_c = unpack_two('0, time_bytes);
	assign sec_c = (seconds_byte[3:0] >= NIBBLE_STOP)
		? SEC_W'(seconds_byte[7:4])
		: (SEC_W'(seconds_byte[7:4]) << 3) + (SEC_W'(seconds_byte[7:4]) << 1)
			+ SEC_W'(seconds_byte[3:0]);

	always_ff @(posedge clk) begin
		if (en1) begin
			dhi_s1 <= dhi_c;
			dlo_s1 <= date_bytes[15:0];
			tim_s1 <= tim_c.acc[TIM_W-1:0];
			sec_s1 <= sec_c;
		end
	end

	// stage 2: lower date bytes, hour reciprocal product
	unp_t               date_c;
	logic [DATE_W-1:0]  date_s2;
	logic [29:0]        tprod_s2;
	logic [TIM_W-1:0]   tim_s2;
	logic [SEC_W-1:0]   sec_s2;

	assign date_c = unpack_two(dhi_s1, dlo_s1);

	always_ff @(posedge clk) begin
		if (en2) begin
			date_s2  <= date_c.acc;
			tprod_s2 <= 30'(tim_s1) * 30'(RECIP_100_T);
			tim_s2   <= tim_s1;
			sec_s2   <= sec_s1;
		end
	end

	// stage 3: date / 1000 product, hours and minutes
	logic [HR_W-1:0]    hr_c;
	logic [56:0]        dprod_s3;
	logic [DATE_W-1:0]  date_s3;
	logic [HR_W-1:0]    hr_s3;
	logic [MN_W-1:0]    mn_s3;
	logic [SEC_W-1:0]   sec_s3;

	assign hr_c = tprod_s2[SHIFT_100_T +: HR_W];

	always_ff @(posedge clk) begin
		if (en3) begin
			dprod_s3 <= 57'(date_s2) * 57'(RECIP_1000_D);
			date_s3  <= date_s2;
			hr_s3    <= hr_c;
			mn_s3    <= MN_W'(tim_s2 - TIM_W'(hr_c) * TIM_W'(100));
			sec_s3   <= sec_s2;
		end
	end

	// stage 4: day of year, /100 product, seconds within the day
	logic [Q1_W-1:0]    q1_c;
	logic [36:0]        cprod_s4;
	logic [Q1_W-1:0]    q1_s4;
	logic [DAY_W-1:0]   day_s4;
	logic [TSEC_W-1:0]  tsec_s4;

	assign q1_c = dprod_s3[SHIFT_1000_D +: Q1_W];

	always_ff @(posedge clk) begin
		if (en4) begin
			cprod_s4 <= 37'(q1_c) * 37'(RECIP_100_D);
			q1_s4    <= q1_c;
			day_s4   <= DAY_W'(date_s3 - DATE_W'(q1_c) * DATE_W'(1000));
			tsec_s4  <= TSEC_W'(hr_s3) * TSEC_W'(3600) + TSEC_W'(mn_s3) * TSEC_W'(60)
				+ TSEC_W'(sec_s3);
		end
	end

	// stage 5: century and year
	logic [CQ_W-1:0]    cq_c;
	logic [6:0]         yy_c;
	logic [YEAR_W-1:0]  year_s5;
	logic [DAY_W-1:0]   day_s5;
	logic [TSEC_W-1:0]  tsec_s5;

	assign cq_c = cprod_s4[SHIFT_100_D +: CQ_W];
	assign yy_c = 7'(q1_s4 - Q1_W'(cq_c) * Q1_W'(100));

	always_ff @(posedge clk) begin
		if (en5) begin
			year_s5 <= ((cq_c == CQ_W'(1)) ? YEAR_2000 : YEAR_1900) + YEAR_W'(yy_c);
			day_s5  <= day_s4;
			tsec_s5 <= tsec_s4;
		end
	end

	// stage 6: day count from the epoch
	logic [YEAR_W-1:0]         ym1_c;
	logic [DAYS_W-1:0]         cent_c;
	logic [DAYS_W-1:0]         quad_c;
	logic signed [DAYS_W-1:0]  leaps_c;
	logic signed [DAYS_W-1:0]  yoff_c;
	logic signed [DAYS_W-1:0]  days_s6;
	logic [TSEC_W-1:0]         tsec_s6;

	assign ym1_c = year_s5 - YEAR_W'(1);

	always_comb begin
		priority if (ym1_c >= YEAR_2000) begin
			cent_c = DAYS_W'(20);
			quad_c = DAYS_W'(5);
		end else if (ym1_c >= YEAR_1900) begin
			cent_c = DAYS_W'(19);
			quad_c = DAYS_W'(4);
		end else begin
			cent_c = DAYS_W'(18);
			quad_c = DAYS_W'(4);
		end
	end

	assign leaps_c = $signed(DAYS_W'(ym1_c >> 2) - cent_c + quad_c - DAYS_W'(LEAPS_1970));
	assign yoff_c  = $signed(DAYS_W'(year_s5) - DAYS_W'(YEAR_1970));

	always_ff @(posedge clk) begin
		if (en6) begin
			days_s6 <= yoff_c * $signed(DAYS_W'(365)) + leaps_c
				+ $signed(DAYS_W'(day_s5)) - $signed(DAYS_W'(1));
			tsec_s6 <= tsec_s5;
		end
	end

	// stage 7: whole days to seconds
	logic signed [DSEC_W-1:0]  dsec_s7;
	logic [TSEC_W-1:0]         tsec_s7;

	always_ff @(posedge clk) begin
		if (en7) begin
			dsec_s7 <= DSEC_W'(days_s6) * $signed(DSEC_W'(86400));
			tsec_s7 <= tsec_s6;
		end
	end

	// stage 8: output register
	logic signed [DSEC_W-1:0] sum_c;

	assign sum_c = dsec_s7 + $signed(DSEC_W'(tsec_s7));

	always_ff @(posedge clk) begin
		if (en8) begin
			epoch_seconds <= OUT_W'(sum_c);
		end
	end

	// ------------------------------------------------------------------
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && v_s1 && v_s4 && v_s7))
		else $error("input stalled while the pipeline has a bubble");

	a_year_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (year_s5 >= YEAR_1900 && year_s5 <= YEAR_2000 + YEAR_W'(99)))
		else $error("year outside 1900 to 2099");

	a_split_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (day_s4 < DAY_W'(1000) && tsec_s4 < TSEC_W'(586100)))
		else $error("reciprocal division gave a remainder out of range");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (epoch_seconds >= -33'sd2209075200))
		else $error("result below the earliest reachable date");

endmodule

`default_nettype wire

// File: bench/packed_julian_date_to_epoch_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packed_julian_date_to_epoch_checker
// Watches both channels of the packed Julian date converter, works out the
// epoch seconds of every accepted request and compares them, in order, with
// the results that leave the block.
// ----------------------------------------------------------------------------
module packed_julian_date_to_epoch_checker
	import pjd2e_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	input  wire logic                    in_stall,
	input  wire logic [31:0]             date_bytes,
	input  wire logic [15:0]             time_bytes,
	input  wire logic [7:0]              seconds_byte,
	input  wire logic                    out_valid,
	input  wire logic                    out_stall,
	input  wire logic signed [OUT_W-1:0] epoch_seconds,
	output int                           mismatches,
	output int                           outstanding
);

	localparam longint EPOCH_YEAR  = 1970;
	localparam int     REPORT_MAX  = 10;

	logic signed [OUT_W-1:0] expected_epochs[$];

	// digits high nibble first; a sign-range low nibble ends the number
	function automatic int unsigned packed_value(logic [31:0] word, int nbytes);
		int unsigned acc;
		logic [7:0] b;
		acc = 0;
		for (int i = nbytes - 1; i >= 0; i--) begin
			b = word[8*i +: 8];
			acc = acc * 10 + b[7:4];
			if (b[3:0] >= NIBBLE_STOP)
				break;
			acc = acc * 10 + b[3:0];
		end
		return acc;
	endfunction

	function automatic longint leap_days_before(longint yr);
		longint y;
		y = yr - 1;
		return y / 4 - y / 100 + y / 400;
	endfunction

	function automatic logic signed [OUT_W-1:0] epoch_of_record(logic [31:0] d,
			logic [15:0] t, logic [7:0] s);
		int unsigned date_v;
		int unsigned time_v;
		int unsigned sec_v;
		longint      yr;
		longint      days;
		longint      total;
		date_v = packed_value(d, 4);
		time_v = packed_value({16'h0, t}, 2);
		sec_v  = packed_value({24'h0, s}, 1);
		yr = ((date_v / 100000) == 1) ? 2000 : 1900;
		yr = yr + longint'((date_v / 1000) % 100);
		// day zero falls on the last day of the year before
		days = 365 * (yr - EPOCH_YEAR) + leap_days_before(yr) - leap_days_before(EPOCH_YEAR)
			+ longint'(date_v % 1000) - 1;
		total = days * 86400 + longint'(time_v / 100) * 3600
			+ longint'(time_v % 100) * 60 + longint'(sec_v);
		return OUT_W'(total);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic signed [OUT_W-1:0] want;
		if (!arst_n) begin
			expected_epochs.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (in_valid && !in_stall)
				expected_epochs.push_back(epoch_of_record(date_bytes, time_bytes, seconds_byte));
			if (out_valid && !out_stall) begin
				if (expected_epochs.size() == 0) begin
					if (mismatches < REPORT_MAX)
						$display("%0t: unexpected result %0d", $realtime, epoch_seconds);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_epochs.pop_front();
					if (epoch_seconds !== want) begin
						if (mismatches < REPORT_MAX)
							$display("%0t: epoch_seconds expected %0d got %0d",
								$realtime, want, epoch_seconds);
						mismatches <= mismatches + 1;
					end
				end
			end
			outstanding <= expected_epochs.size();
		end
	end

endmodule

// File: bench/packed_julian_date_to_epoch_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packed_julian_date_to_epoch_unit_tb
// Drives directed and random packed-decimal date, time and seconds requests
// into the converter under changing source gaps and sink stalls; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module packed_julian_date_to_epoch_unit_tb;
	import pjd2e_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic                    clk          = 1'b0;
	logic                    arst_n       = 1'b0;
	logic                    in_valid     = 1'b0;
	logic                    in_stall;
	logic [31:0]             date_bytes   = '0;
	logic [15:0]             time_bytes   = '0;
	logic [7:0]              seconds_byte = '0;
	logic                    out_valid;
	logic                    out_stall    = 1'b0;
	logic signed [OUT_W-1:0] epoch_seconds;

	int source_idle_pct = 0;
	int sink_stall_pct  = 0;
	int cycle_count     = 0;
	int mismatches;
	int outstanding;

	packed_julian_date_to_epoch_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.date_bytes    (date_bytes),
		.time_bytes    (time_bytes),
		.seconds_byte  (seconds_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.epoch_seconds (epoch_seconds)
	);

	packed_julian_date_to_epoch_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.date_bytes    (date_bytes),
		.time_bytes    (time_bytes),
		.seconds_byte  (seconds_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.epoch_seconds (epoch_seconds),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		out_stall   <= ($urandom_range(99) < sink_stall_pct);
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [7:0] bcd_byte(int unsigned v);
		return {4'(v / 10), 4'(v % 10)};
	endfunction

	// one nibble among the lowest ones becomes a non-decimal code
	function automatic logic [31:0] spoil_nibble(logic [31:0] w, int nibbles);
		int unsigned pos;
		pos = $urandom_range(nibbles - 1);
		w[4*pos +: 4] = 4'($urandom_range(15, 10));
		return w;
	endfunction

	task automatic send_request(input logic [31:0] d, input logic [15:0] t,
			input logic [7:0] s);
		while ($urandom_range(99) < source_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		date_bytes   <= d;
		time_bytes   <= t;
		seconds_byte <= s;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_random(int count);
		int unsigned kind;
		int unsigned day;
		int unsigned cent;
		logic [31:0] d;
		logic [15:0] t;
		logic [7:0]  s;
		for (int k = 0; k < count; k++) begin
			kind = $urandom_range(99);
			if (kind < 70) begin
				cent = ($urandom_range(9) < 3) ? $urandom_range(9) : $urandom_range(1);
				day  = $urandom_range(366, 1);
				d = {4'h0, 4'(cent), bcd_byte($urandom_range(99)), bcd_byte(day / 10),
					4'(day % 10), 4'($urandom_range(15, 10))};
			end else if (kind < 90) begin
				for (int n = 0; n < 8; n++)
					d[4*n +: 4] = 4'($urandom_range(9));
				d = spoil_nibble(d, 8);
				if ($urandom_range(1))
					d = spoil_nibble(d, 8);
			end else begin
				d = $urandom;
			end
			kind = $urandom_range(99);
			if (kind < 70)
				t = {bcd_byte($urandom_range(23)), bcd_byte($urandom_range(59))};
			else if (kind < 90)
				t = 16'(spoil_nibble({16'h0, bcd_byte($urandom_range(99)),
					bcd_byte($urandom_range(99))}, 4));
			else
				t = 16'($urandom);
			kind = $urandom_range(99);
			if (kind < 70)
				s = bcd_byte($urandom_range(59));
			else if (kind < 90)
				s = 8'(spoil_nibble({24'h0, bcd_byte($urandom_range(99))}, 2));
			else
				s = 8'($urandom);
			send_request(d, t, s);
		end
	endtask

	initial begin
		source_idle_pct = 38;
		sink_stall_pct  = 80;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lowest result: day zero of 1900 at midnight
		send_request(32'h0000000C, 16'h0000, 8'h00);
		send_request(32'h0070001C, 16'h0000, 8'h00);
		send_request(32'h0199999F, 16'h9999, 8'h99);
		send_request(32'hFFFFFFFF, 16'hFFFF, 8'hFF);
		// no sign nibble anywhere, all eight digits taken
		send_request(32'h00000000, 16'h0000, 8'h00);
		send_request(32'h99999999, 16'h9999, 8'h99);
		send_request(32'h0100366C, 16'h2359, 8'h59);
		send_request(32'h0000365C, 16'h2359, 8'h59);
		send_request(32'h0099365F, 16'h0001, 8'h01);
		// early stop in each of the upper three bytes of the date
		send_request(32'h1B000000, 16'h1200, 8'h30);
		send_request(32'h01CFFFFF, 16'h0030, 8'h45);
		send_request(32'h0123AFFF, 16'h0100, 8'h00);
		// century digit above nine, and a plain two
		send_request(32'h0F12345C, 16'h0000, 8'h00);
		send_request(32'h0212345C, 16'h1010, 8'h10);
		send_request(32'h0112345D, 16'hAF00, 8'hF9);
		send_request(32'h0005100C, 16'h12FB, 8'h5A);
		send_request(32'hF0F0F0FC, 16'hF9F9, 8'hFF);
		send_request(32'h0120001C, 16'h0000, 8'h00);
		send_request(32'hAAAAAAAA, 16'hAAAA, 8'hAA);
		send_request(32'h55555555, 16'h5555, 8'h55);

		send_random(480);
		source_idle_pct = 80;
		sink_stall_pct  = 38;
		send_random(480);
		source_idle_pct = 0;
		sink_stall_pct  = 0;
		send_random(490);

		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
